### hdl/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared types, codes and constants of the min/max magnetometer calibrator.
// ----------------------------------------------------------------------------
package mmc_pkg;

  // Default sample width of the raw magnetometer counts.
  localparam int SAMPLE_BITS_DEF = 16;

  // Width of the raw sample fields on the stream.
  localparam int MAG_FIELD_W = 16;

  // Number of axes and the width of an axis index.
  localparam int NUM_AXES = 3;
  localparam int AXIS_W = 2;
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  // Configuration register widths and reset values.
  localparam int TARGET_W = 16;
  localparam int UT_W = 24;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd500;
  localparam logic [UT_W-1:0] UT_RESET = 24'd65536;

  // Configuration register indexes.
  localparam logic REG_TARGET_COUNT = 1'b0;
  localparam logic REG_UT_PER_COUNT = 1'b1;

  // Reported phase codes.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_COLLECT = 3'd2;
  localparam logic [2:0] PH_COMPUTE = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  // Scale factors are unsigned Q2.14.
  localparam int SCALE_W = 16;

  // Scale division: 16 quotient bits plus one bit that flags overflow.
  localparam int DIV_STEPS = SCALE_W + 1;

  // Field product split: width of the low part of the magnitude.
  localparam int MAG_LO_W = 17;
  localparam int ROUND_BIAS = 16384;
  localparam int FIELD_W = 32;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] FIELD_MIN = 32'h8000_0000;

  // Built-in calibration, offsets in half counts and scales in Q2.14.
  localparam int DFLT_OFF_HALF [NUM_AXES] = '{10, -7, 15};
  localparam logic [SCALE_W-1:0] DFLT_SCALE [NUM_AXES] = '{16'd15353, 16'd15633, 16'd18516};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              take_sample;
    logic              clear_stats;
    logic              collect;
    logic              load_dflt;
    logic              cal_begin;
    logic              div_load;
    logic              div_step;
    logic              div_store;
    logic              mul_abs;
    logic              mul_mag;
    logic              mul_part;
    logic              mul_fin;
    logic              out_load;
    logic              out_valid;
    logic [2:0]        out_phase;
    logic [AXIS_W-1:0] axis;
  } mmc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_hit;
  } mmc_sts_t;

endpackage

### hdl/magnetometer_minmax_calibrator_unit.sv
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibrator_unit
// Min/max hard- and soft-iron calibration of a three-axis magnetometer.
// ----------------------------------------------------------------------------
// Every request carries one raw X/Y/Z sample and yields exactly one result
// request. After reset the unit is idle: the first request without start_req
// loads built-in offsets and scales and reports phase done with zero fields.
// A request with start_req set clears the per-axis minimum, maximum and sample
// count and enters collecting; the sample itself is not used. While collecting,
// each sample widens the per-axis min/max until the programmed target count of
// samples has been seen, then the next request computes offset = (max+min)/2
// and the scale of each axis as the mean half span over its own half span
// (saturating when an axis never moved). In the done phase each request
// returns the calibrated field (raw - offset) * scale * ut_per_count as
// saturated signed Q15.16 microtesla with valid_res set; all other requests
// return zero fields with valid_res clear. The phase after the request is
// returned in every result.
// Sequencing: one request is worked on at a time. Idle, start and collecting
// requests go from acceptance through the push state to the result register;
// a done request takes four steps per axis through the two-stage field
// multiply; the compute request runs the bit-serial divider that produces
// 17 quotient bits per axis, one per cycle, with a load and a store step
// around each axis. The result register lets a new request be accepted
// while the previous result still waits to be taken.
// Configuration may be written whenever no request is outstanding.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibrator_unit #(
  parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Sample requests.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [47:0]               s_axis_tdata,  // mag_x, mag_y, mag_z
  input  logic [0:0]                s_axis_tuser,  // start_req
  // Result requests.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [95:0]               m_axis_tdata,  // field_x, field_y, field_z
  output logic [3:0]                m_axis_tuser,  // valid_res, phase[2:0]
  // Configuration writes.
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mmc_pkg::UT_W-1:0]  cfg_data
);

  mmc_pkg::mmc_cmd_t cmd;
  mmc_pkg::mmc_sts_t sts;

  // The controller owns the phase machine and both handshakes.
  mmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .start_req (s_axis_tuser[0]),
    .s_ready   (s_axis_tready),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the statistics, the calibration and the result register.
  mmc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mag       (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

### hdl/mmc_ctrl.sv
// ----------------------------------------------------------------------------
// mmc_ctrl
// Controller: calibration phase, request handshake and step sequencing.
// ----------------------------------------------------------------------------
module mmc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  input  logic              start_req,
  output logic              s_ready,
  output logic              m_valid,
  input  logic              m_ready,
  input  mmc_pkg::mmc_sts_t sts,
  output mmc_pkg::mmc_cmd_t cmd
);

  localparam int CNT_W = $clog2(mmc_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mmc_pkg::DIV_STEPS - 1);

  typedef enum logic [8:0] {
    ST_WAIT   = 9'b000000001,
    ST_DLOAD  = 9'b000000010,
    ST_DSTEP  = 9'b000000100,
    ST_DSTORE = 9'b000001000,
    ST_MABS   = 9'b000010000,
    ST_MMAG   = 9'b000100000,
    ST_MPART  = 9'b001000000,
    ST_MFIN   = 9'b010000000,
    ST_PUSH   = 9'b100000000
  } seq_state_t;

  typedef enum logic [4:0] {
    CP_IDLE    = 5'b00001,
    CP_START   = 5'b00010,
    CP_COLLECT = 5'b00100,
    CP_COMPUTE = 5'b01000,
    CP_DONE    = 5'b10000
  } cal_phase_t;

  seq_state_t                  state, state_next;
  cal_phase_t                  cal_phase, cal_phase_next;
  logic [mmc_pkg::AXIS_W-1:0]  axis, axis_next;
  logic [CNT_W-1:0]            cnt, cnt_next;
  logic                        res_valid, res_valid_next;
  logic                        m_valid_next;

  function automatic logic [2:0] phase_code(input cal_phase_t p);
    logic [2:0] c;
    unique case (p)
      CP_START:   c = mmc_pkg::PH_START;
      CP_COLLECT: c = mmc_pkg::PH_COLLECT;
      CP_COMPUTE: c = mmc_pkg::PH_COMPUTE;
      CP_DONE:    c = mmc_pkg::PH_DONE;
      default:    c = mmc_pkg::PH_IDLE;
    endcase
    return c;
  endfunction

  always_comb begin
    state_next     = state;
    cal_phase_next = cal_phase;
    axis_next      = axis;
    cnt_next       = cnt;
    res_valid_next = res_valid;
    s_ready        = 1'b0;
    cmd            = '0;
    cmd.axis       = axis;
    cmd.out_valid  = res_valid;
    cmd.out_phase  = phase_code(cal_phase);

    unique case (state)
      ST_WAIT: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.take_sample = 1'b1;
          axis_next       = '0;
          res_valid_next  = 1'b0;
          state_next      = ST_PUSH;
          if (start_req) begin
            cmd.clear_stats = 1'b1;
            cal_phase_next  = CP_COLLECT;
          end else begin
            unique case (cal_phase)
              CP_START: begin
                cmd.clear_stats = 1'b1;
                cal_phase_next  = CP_COLLECT;
              end
              CP_COLLECT: begin
                cmd.collect = 1'b1;
                if (sts.count_hit) begin
                  cal_phase_next = CP_COMPUTE;
                end
              end
              CP_COMPUTE: begin
                cmd.cal_begin  = 1'b1;
                cal_phase_next = CP_DONE;
                state_next     = ST_DLOAD;
              end
              CP_DONE: begin
                res_valid_next = 1'b1;
                state_next     = ST_MABS;
              end
              default: begin
                cmd.load_dflt  = 1'b1;
                cal_phase_next = CP_DONE;
              end
            endcase
          end
        end
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = ST_DSTORE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DSTORE: begin
        cmd.div_store = 1'b1;
        if (axis == mmc_pkg::LAST_AXIS) begin
          state_next = ST_PUSH;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = ST_DLOAD;
        end
      end
      ST_MABS: begin
        cmd.mul_abs = 1'b1;
        state_next  = ST_MMAG;
      end
      ST_MMAG: begin
        cmd.mul_mag = 1'b1;
        state_next  = ST_MPART;
      end
      ST_MPART: begin
        cmd.mul_part = 1'b1;
        state_next   = ST_MFIN;
      end
      ST_MFIN: begin
        cmd.mul_fin = 1'b1;
        if (axis == mmc_pkg::LAST_AXIS) begin
          state_next = ST_PUSH;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = ST_MABS;
        end
      end
      ST_PUSH: begin
        if (!m_valid || m_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_WAIT;
        end
      end
      default: begin
        state_next = ST_WAIT;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      m_valid_next = 1'b1;
    end else if (m_ready) begin
      m_valid_next = 1'b0;
    end else begin
      m_valid_next = m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT;
      cal_phase <= CP_IDLE;
      axis      <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
      m_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      cal_phase <= cal_phase_next;
      axis      <= axis_next;
      cnt       <= cnt_next;
      res_valid <= res_valid_next;
      m_valid   <= m_valid_next;
    end
  end

endmodule

### hdl/mmc_dp.sv
// ----------------------------------------------------------------------------
// mmc_dp
// Datapath: min/max tracking, scale division, field products, output register.
// ----------------------------------------------------------------------------
module mmc_dp #(
  parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_we,
  input  logic                                            cfg_index,
  input  logic [mmc_pkg::UT_W-1:0]                        cfg_data,
  input  logic [mmc_pkg::NUM_AXES-1:0][mmc_pkg::MAG_FIELD_W-1:0] mag,
  input  mmc_pkg::mmc_cmd_t                               cmd,
  output mmc_pkg::mmc_sts_t                               sts,
  output logic [mmc_pkg::NUM_AXES*mmc_pkg::FIELD_W-1:0]   out_data,
  output logic [3:0]                                      out_user
);

  localparam int SB     = SAMPLE_BITS;
  localparam int NA     = mmc_pkg::NUM_AXES;
  localparam int OFF_W  = SB + 2;
  localparam int SUM_W  = SB + 2;
  localparam int NUM_W  = SB + 17;
  localparam int SX6_W  = SB + 3;
  localparam int DSH_W  = SX6_W + mmc_pkg::SCALE_W;
  localparam int D_W    = SB + 3;
  localparam int DABS_W = SB + 2;
  localparam int MAG_W  = SB + 17;
  localparam int LO_W   = mmc_pkg::MAG_LO_W;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int UT_W   = mmc_pkg::UT_W;
  localparam int PLO_W  = LO_W + UT_W;
  localparam int PHI_W  = HI_W + UT_W;
  localparam int TOT_W  = MAG_W + UT_W + 1;
  localparam int R_W    = TOT_W - 15;
  localparam int Q_W    = mmc_pkg::DIV_STEPS;
  localparam int SC_W   = mmc_pkg::SCALE_W;
  localparam int FW     = mmc_pkg::FIELD_W;
  localparam int TW     = mmc_pkg::TARGET_W;

  // Configuration.
  logic [TW-1:0]   target;
  logic [UT_W-1:0] ut;

  // Collection statistics and calibration.
  logic signed [SB-1:0]    amin [NA];
  logic signed [SB-1:0]    amax [NA];
  logic [TW-1:0]           count;
  logic signed [OFF_W-1:0] off [NA];
  logic [SC_W-1:0]         scale [NA];
  logic [SB-1:0]           span [NA];

  // Sample as seen by the calibration, and the captured copy.
  logic signed [SB-1:0]    raw_in [NA];
  logic signed [SB-1:0]    raw_s [NA];

  // Divider.
  logic [NUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [Q_W-1:0]   quo;

  // Field products.
  logic [DABS_W-1:0] d_abs;
  logic              neg;
  logic [MAG_W-1:0]  magn;
  logic [PLO_W-1:0]  plo;
  logic [PHI_W-1:0]  phi;
  logic [FW-1:0]     field_res [NA];

  // Output register.
  logic [FW-1:0] out_field [NA];
  logic          out_valid_res;
  logic [2:0]    out_phase;

  // Combinational helpers.
  logic [TW-1:0]         cnt_inc;
  logic signed [SB:0]    diff_c [NA];
  logic [SUM_W-1:0]      sum_c;
  logic [NUM_W-1:0]      sx3_c;
  logic [SX6_W-1:0]      sx6_c;
  logic signed [D_W-1:0] d_c;
  logic [TOT_W-1:0]      tot_c;
  logic [R_W-1:0]        r_c;
  logic [FW-1:0]         fin_c;

  // Samples wider than the field read the field as an unsigned count.
  for (genvar a = 0; a < NA; a++) begin : g_raw
    if (SB <= mmc_pkg::MAG_FIELD_W) begin : g_narrow
      assign raw_in[a] = mag[a][SB-1:0];
    end else begin : g_wide
      assign raw_in[a] = {{(SB - mmc_pkg::MAG_FIELD_W){1'b0}}, mag[a]};
    end
  end

  always_comb begin
    cnt_inc = (count == '1) ? count : count + 1'b1;
    sts.count_hit = (cnt_inc >= target);
    for (int i = 0; i < NA; i++) begin
      diff_c[i] = (SB + 1)'(amax[i]) - (SB + 1)'(amin[i]);
    end
    sum_c = SUM_W'(span[0]) + SUM_W'(span[1]) + SUM_W'(span[2]);
    sx3_c = NUM_W'(span[cmd.axis]) + NUM_W'({span[cmd.axis], 1'b0});
    sx6_c = SX6_W'({span[cmd.axis], 1'b0}) + SX6_W'({span[cmd.axis], 2'b00});
    d_c   = D_W'(raw_s[cmd.axis]) + D_W'(raw_s[cmd.axis]) - D_W'(off[cmd.axis]);
    tot_c = TOT_W'({phi, {LO_W{1'b0}}}) + TOT_W'(plo) + TOT_W'(mmc_pkg::ROUND_BIAS);
    r_c   = tot_c[TOT_W-1:15];
    if (neg) begin
      fin_c = (r_c > R_W'(mmc_pkg::FIELD_MIN)) ? mmc_pkg::FIELD_MIN : (~r_c[FW-1:0] + 1'b1);
    end else begin
      fin_c = (r_c > R_W'(mmc_pkg::FIELD_MAX)) ? mmc_pkg::FIELD_MAX : r_c[FW-1:0];
    end
  end

  // Configuration and statistics, which the phase machine relies on.
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= mmc_pkg::TARGET_RESET;
      ut     <= mmc_pkg::UT_RESET;
      count  <= '0;
      for (int i = 0; i < NA; i++) begin
        amin[i] <= {1'b0, {(SB - 1){1'b1}}};
        amax[i] <= {1'b1, {(SB - 1){1'b0}}};
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mmc_pkg::REG_TARGET_COUNT: target <= cfg_data[TW-1:0];
          mmc_pkg::REG_UT_PER_COUNT: ut     <= cfg_data;
        endcase
      end
      if (cmd.clear_stats) begin
        count <= '0;
        for (int i = 0; i < NA; i++) begin
          amin[i] <= {1'b0, {(SB - 1){1'b1}}};
          amax[i] <= {1'b1, {(SB - 1){1'b0}}};
        end
      end else if (cmd.collect) begin
        count <= cnt_inc;
        for (int i = 0; i < NA; i++) begin
          if (raw_in[i] < amin[i]) begin
            amin[i] <= raw_in[i];
          end
          if (raw_in[i] > amax[i]) begin
            amax[i] <= raw_in[i];
          end
        end
      end
    end
  end

  // Calibration, divider and field arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      for (int i = 0; i < NA; i++) begin
        raw_s[i] <= raw_in[i];
      end
    end
    if (cmd.load_dflt) begin
      for (int i = 0; i < NA; i++) begin
        off[i]   <= OFF_W'(mmc_pkg::DFLT_OFF_HALF[i]);
        scale[i] <= mmc_pkg::DFLT_SCALE[i];
      end
    end
    if (cmd.cal_begin) begin
      for (int i = 0; i < NA; i++) begin
        off[i]  <= OFF_W'(amax[i]) + OFF_W'(amin[i]);
        span[i] <= diff_c[i][SB] ? '0 : diff_c[i][SB-1:0];
      end
    end
    if (cmd.div_load) begin
      rem <= NUM_W'({sum_c, 15'b0}) + sx3_c;
      dsh <= {sx6_c, {mmc_pkg::SCALE_W{1'b0}}};
    end
    if (cmd.div_step) begin
      if (DSH_W'(rem) >= dsh) begin
        rem <= rem - NUM_W'(dsh);
        quo <= {quo[Q_W-2:0], 1'b1};
      end else begin
        quo <= {quo[Q_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
    if (cmd.div_store) begin
      scale[cmd.axis] <= quo[Q_W-1] ? '1 : quo[SC_W-1:0];
    end
    if (cmd.mul_abs) begin
      neg   <= d_c[D_W-1];
      d_abs <= d_c[D_W-1] ? DABS_W'(-d_c) : DABS_W'(d_c);
    end
    if (cmd.mul_mag) begin
      magn <= MAG_W'(d_abs) * MAG_W'(scale[cmd.axis]);
    end
    if (cmd.mul_part) begin
      plo <= PLO_W'(magn[LO_W-1:0]) * PLO_W'(ut);
      phi <= PHI_W'(magn[MAG_W-1:LO_W]) * PHI_W'(ut);
    end
    if (cmd.mul_fin) begin
      field_res[cmd.axis] <= fin_c;
    end
    if (cmd.out_load) begin
      out_valid_res <= cmd.out_valid;
      out_phase     <= cmd.out_phase;
      for (int i = 0; i < NA; i++) begin
        out_field[i] <= cmd.out_valid ? field_res[i] : '0;
      end
    end
  end

  assign out_data = {out_field[2], out_field[1], out_field[0]};
  assign out_user = {out_phase, out_valid_res};

endmodule
